>>> hdl/assert_macros.svh
// Assertion macros used by the checker file ppz_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held low.
`define PPZ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PPZ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ppz_pkg.sv
// ----------------------------------------------------------------------------
// ppz_pkg
// Widths, register indexes and command codes of the point projection block.
// ----------------------------------------------------------------------------
package ppz_pkg;

    localparam int IMG_WIDTH_DEF  = 640;
    localparam int IMG_HEIGHT_DEF = 480;

    localparam int COORD_W   = 24;
    localparam int IDX_W     = 19;
    localparam int DEPTH_W   = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;

    localparam logic [DEPTH_W-1:0] LIMIT_RESET = 16'd10000;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TZ     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd7;

    localparam logic CMD_PROJECT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

endpackage

>>> hdl/ppz_ram.sv
// ----------------------------------------------------------------------------
// ppz_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module ppz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

>>> hdl/point_projection_zbuffer.sv
// ----------------------------------------------------------------------------
// point_projection_zbuffer
// Projects world points through a pinhole camera into a z-buffered depth map.
// ----------------------------------------------------------------------------
// After reset the block sweeps the depth store to zero, one cell per cycle, and
// busy stays high until all IMG_WIDTH*IMG_HEIGHT cells (307200 by default) are
// clear; config writes are taken meanwhile. A read command gives one word on
// o_done in the cycle in which busy drops. A project command gives no word: one
// shared 26x23 multiplier forms the nine rotation products and the two focal
// products per axis, and a one-bit-a-cycle restoring divider forms a 22-bit
// quotient per axis; a point that misses the image or fails the depth test
// ends early. Results are shown for exactly one cycle and cannot be held off.
module point_projection_zbuffer #(
    parameter int IMG_WIDTH  = ppz_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ppz_pkg::IMG_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic                                i_command,
    input  logic signed [ppz_pkg::COORD_W-1:0]  i_point_x,
    input  logic signed [ppz_pkg::COORD_W-1:0]  i_point_y,
    input  logic signed [ppz_pkg::COORD_W-1:0]  i_point_z,
    input  logic [ppz_pkg::IDX_W-1:0]           i_cell_index,
    input  logic                                i_cfg_we,
    input  logic [ppz_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ppz_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                o_done,
    output logic [ppz_pkg::DEPTH_W-1:0]         o_depth_mm,
    output logic [ppz_pkg::IDX_W-1:0]           o_cell_index_out
);

    import ppz_pkg::*;

    localparam int CELLS = IMG_WIDTH * IMG_HEIGHT;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int LIM_X = IMG_WIDTH * 256;
    localparam int LIM_Y = IMG_HEIGHT * 256;

    typedef enum logic [14:0] {
        S_CLR  = 15'b000000000000001,
        S_IDLE = 15'b000000000000010,
        S_DM   = 15'b000000000000100,
        S_DA   = 15'b000000000001000,
        S_MAG  = 15'b000000000010000,
        S_PM   = 15'b000000000100000,
        S_PA   = 15'b000000001000000,
        S_CHK  = 15'b000000010000000,
        S_DIV  = 15'b000000100000000,
        S_FIN  = 15'b000001000000000,
        S_DEP  = 15'b000010000000000,
        S_PRD  = 15'b000100000000000,
        S_PUPD = 15'b001000000000000,
        S_CRD  = 15'b010000000000000,
        S_CWB  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0]   r_rot [3];
    logic [CFG_W-1:0]   r_trans;
    logic [23:0]        r_tz;
    logic [39:0]        r_focal;
    logic [39:0]        r_center;
    logic [DEPTH_W-1:0] r_limit;

    // datapath
    logic signed [24:0] r_dx, r_dy, r_dz;
    logic signed [43:0] r_acc, r_vx, r_vy, r_vz;
    logic signed [48:0] r_prod;
    logic [1:0]         r_row, r_col;
    logic               r_half, r_axis, r_neg;
    logic [42:0]        r_mag;
    logic [63:0]        r_num;
    logic [42:0]        r_rem;
    logic [21:0]        r_q;
    logic [4:0]         r_cnt;
    logic [11:0]        r_u, r_v;
    logic [26:0]        r_zk;
    logic [AW-1:0]      r_cell;
    logic [IDX_W-1:0]   r_idx;
    logic               r_oor;
    logic [AW-1:0]      r_clr;
    logic               r_done;
    logic [DEPTH_W-1:0] r_depth;
    logic [IDX_W-1:0]   r_idx_out;

    // shared multiplier
    logic signed [25:0] m_a;
    logic signed [22:0] m_b;
    logic signed [48:0] m_p;
    logic [47:0]        rot_row;
    logic [15:0]        rot_ent;
    logic [19:0]        f_axis, c_axis;

    // step results
    logic signed [43:0] dot_sum;
    logic               chk_ovf;
    logic [43:0]        div_t;
    logic               div_ge;
    logic signed [23:0] q_abs, q_floor;
    logic signed [25:0] s_sum;
    logic               fin_drop;
    logic [11:0]        fin_pix;
    logic [52:0]        vz_u, zs;
    logic               zk_over;
    logic [DEPTH_W-1:0] ram_rdata, ram_wdata;
    logic [AW-1:0]      ram_addr;
    logic               ram_we, upd_wr;

    assign rot_row = r_rot[r_row];
    assign f_axis  = r_axis ? r_focal[39:20] : r_focal[19:0];
    assign c_axis  = r_axis ? r_center[39:20] : r_center[19:0];

    always_comb begin
        case (r_col)
            2'd0:    rot_ent = rot_row[15:0];
            2'd1:    rot_ent = rot_row[31:16];
            2'd2:    rot_ent = rot_row[47:32];
            default: rot_ent = '0;
        endcase
        m_a = '0;
        m_b = '0;
        if (r_state == S_DM) begin
            case (r_col)
                2'd0:    m_a = {r_dx[24], r_dx};
                2'd1:    m_a = {r_dy[24], r_dy};
                2'd2:    m_a = {r_dz[24], r_dz};
                default: m_a = '0;
            endcase
            m_b = {{7{rot_ent[15]}}, rot_ent};
        end else begin
            m_a = {6'b0, f_axis};
            m_b = r_half ? {2'b0, r_mag[42:22]} : {1'b0, r_mag[21:0]};
        end
        m_p = m_a * m_b;
    end

    always_comb begin
        dot_sum = r_acc + r_prod[43:0];
        chk_ovf = {1'b0, r_num} >= {r_vz[42:0], 22'b0};
        div_t   = {r_rem, r_num[21]};
        div_ge  = div_t >= {1'b0, r_vz[42:0]};
        // floor quotient: a negative numerator with a remainder rounds down
        q_abs   = {2'b0, r_q};
        if (!r_neg) begin
            q_floor = q_abs;
        end else if (r_rem == '0) begin
            q_floor = -q_abs;
        end else begin
            q_floor = -q_abs - 24'sd1;
        end
        s_sum    = {{2{q_floor[23]}}, q_floor} + $signed({6'b0, c_axis});
        fin_drop = (s_sum < -26'sd256) || ((s_sum == -26'sd256) && (r_rem == '0))
                 || (s_sum >= $signed(26'(r_axis ? LIM_Y : LIM_X)));
        fin_pix  = s_sum[25] ? 12'd0 : s_sum[19:8];
        // depth times 1000 as 1024 - 16 - 8
        vz_u     = {10'b0, r_vz[42:0]};
        zs       = (vz_u << 10) - (vz_u << 4) - (vz_u << 3);
        zk_over  = r_zk >= {11'b0, r_limit};
        upd_wr   = (ram_rdata == '0) || ({11'b0, ram_rdata} > r_zk);
    end

    always_comb begin
        ram_addr  = r_cell;
        ram_we    = 1'b0;
        ram_wdata = '0;
        case (r_state)
            S_CLR: begin
                ram_addr = r_clr;
                ram_we   = 1'b1;
            end
            S_PUPD: begin
                ram_we    = upd_wr;
                ram_wdata = r_zk[DEPTH_W-1:0];
            end
            S_CWB: begin
                ram_we = !r_oor;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr == AW'(CELLS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_command == CMD_READ) ? S_CRD : S_DM;
                end
            end
            S_DM:   n_state = S_DA;
            S_DA: begin
                if (r_col != 2'd2) begin
                    n_state = S_DM;
                end else if (r_row != 2'd2) begin
                    n_state = S_DM;
                end else begin
                    n_state = (dot_sum <= 44'sd0) ? S_IDLE : S_MAG;
                end
            end
            S_MAG:  n_state = S_PM;
            S_PM:   n_state = S_PA;
            S_PA:   n_state = r_half ? S_CHK : S_PM;
            S_CHK:  n_state = chk_ovf ? S_IDLE : S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_FIN;
            S_FIN: begin
                if (fin_drop) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = r_axis ? S_DEP : S_MAG;
                end
            end
            S_DEP:  n_state = S_PRD;
            S_PRD:  n_state = zk_over ? S_IDLE : S_PUPD;
            S_PUPD: n_state = S_IDLE;
            S_CRD:  n_state = S_CWB;
            S_CWB:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_done   <= 1'b0;
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_trans  <= '0;
            r_tz     <= '0;
            r_focal  <= '0;
            r_center <= '0;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_CWB);
            if (r_state == S_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROT_X:  r_rot[0] <= i_cfg_data;
                    CFG_ROT_Y:  r_rot[1] <= i_cfg_data;
                    CFG_ROT_Z:  r_rot[2] <= i_cfg_data;
                    CFG_TRANS:  r_trans  <= i_cfg_data;
                    CFG_TZ:     r_tz     <= i_cfg_data[23:0];
                    CFG_FOCAL:  r_focal  <= i_cfg_data[39:0];
                    CFG_CENTER: r_center <= i_cfg_data[39:0];
                    CFG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx  <= i_cell_index;
                r_oor  <= 32'(i_cell_index) >= 32'(CELLS);
                r_cell <= AW'(i_cell_index);
                r_dx   <= {i_point_x[23], i_point_x} - {r_trans[23], r_trans[23:0]};
                r_dy   <= {i_point_y[23], i_point_y} - {r_trans[47], r_trans[47:24]};
                r_dz   <= {i_point_z[23], i_point_z} - {r_tz[23], r_tz};
                r_row  <= '0;
                r_col  <= '0;
                r_acc  <= '0;
            end
            S_DM: r_prod <= m_p;
            S_DA: begin
                if (r_col == 2'd2) begin
                    r_acc <= '0;
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                    case (r_row)
                        2'd0:    r_vx <= dot_sum;
                        2'd1:    r_vy <= dot_sum;
                        default: r_vz <= dot_sum;
                    endcase
                    r_axis <= 1'b0;
                end else begin
                    r_acc <= dot_sum;
                    r_col <= r_col + 1'b1;
                end
            end
            S_MAG: begin
                r_neg  <= r_axis ? r_vy[43] : r_vx[43];
                r_mag  <= r_axis ? (r_vy[43] ? 43'(-r_vy) : r_vy[42:0])
                                 : (r_vx[43] ? 43'(-r_vx) : r_vx[42:0]);
                r_half <= 1'b0;
            end
            S_PM: r_prod <= m_p;
            S_PA: begin
                if (!r_half) begin
                    r_num  <= {22'b0, r_prod[41:0]};
                    r_half <= 1'b1;
                end else begin
                    r_num <= r_num + {1'b0, r_prod[40:0], 22'b0};
                end
            end
            S_CHK: begin
                r_rem <= {1'b0, r_num[63:22]};
                r_q   <= '0;
                r_cnt <= 5'd21;
            end
            S_DIV: begin
                r_rem <= div_ge ? 43'(div_t - {1'b0, r_vz[42:0]}) : div_t[42:0];
                r_q   <= {r_q[20:0], div_ge};
                r_num <= r_num << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                if (r_axis) begin
                    r_v <= fin_pix;
                end else begin
                    r_u    <= fin_pix;
                    r_axis <= 1'b1;
                end
            end
            S_DEP: begin
                r_zk   <= zs[52:26];
                r_cell <= AW'(int'(r_v) * IMG_WIDTH + int'(r_u));
            end
            S_CWB: begin
                r_depth   <= r_oor ? '0 : ram_rdata;
                r_idx_out <= r_idx;
            end
            default: ;
        endcase
    end

    ppz_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_depth_mm       = r_depth;
    assign o_cell_index_out = r_idx_out;

endmodule

>>> hdl/ppz_chk.sv
// ----------------------------------------------------------------------------
// ppz_chk
// Port-level checks of the point projection block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppz_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_command,
    input logic o_busy,
    input logic o_done
);

    import ppz_pkg::*;

    // a read word lands after the read and write-back states that follow a taken read command
    `PPZ_ASSERT(a_read_latency, i_clk, i_rst_n, (i_start && !o_busy && i_command == CMD_READ) |-> ##3 o_done, "read word missing")
    // any accepted word keeps the block busy in the next cycle
    `PPZ_ASSERT(a_busy_after_start, i_clk, i_rst_n, (i_start && !o_busy) |=> o_busy, "not busy after start")
    `PPZ_ASSERT(a_done_when_idle, i_clk, i_rst_n, o_done |-> !o_busy, "result while busy")
    `PPZ_ASSERT(a_done_after_work, i_clk, i_rst_n, o_done |-> $past(o_busy), "result without work")
    `PPZ_ASSERT_ALWAYS(a_done_single, i_clk, o_done |=> !o_done, "result strobe held")

endmodule

bind point_projection_zbuffer ppz_chk u_ppz_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_start   (i_start),
    .i_command (i_command),
    .o_busy    (o_busy),
    .o_done    (o_done)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the point projection depth map block. A predictor keeps its own
// depth map and camera setup, works out the word that every read command
// should return, and compares each word on o_done with the oldest one held.
// ----------------------------------------------------------------------------
module testbench;
    import ppz_pkg::*;

    localparam int IMG_W     = IMG_WIDTH_DEF;
    localparam int IMG_H     = IMG_HEIGHT_DEF;
    localparam int CELLS     = IMG_W * IMG_H;
    localparam int WDOG_MAX  = 1000000;
    localparam int SETTLE    = 120;
    localparam longint Q26   = 64'sd67108864;
    localparam longint Q14   = 16384;

    typedef struct {
        logic                      cmd;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [IDX_W-1:0]          idx;
    } t_point_cmd;

    typedef struct {
        logic [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]   idx;
    } t_cell_word;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_start;
    logic                      o_busy;
    logic                      i_command;
    logic signed [COORD_W-1:0] i_point_x;
    logic signed [COORD_W-1:0] i_point_y;
    logic signed [COORD_W-1:0] i_point_z;
    logic [IDX_W-1:0]          i_cell_index;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      o_done;
    logic [DEPTH_W-1:0]        o_depth_mm;
    logic [IDX_W-1:0]          o_cell_index_out;

    point_projection_zbuffer u_top (.*);

    // predictor copy of the registers and the depth map
    logic [47:0]        rot_rows [3];
    logic [47:0]        trans_xy;
    logic [23:0]        trans_z;
    logic [39:0]        focal_pair;
    logic [39:0]        center_pair;
    logic [15:0]        depth_limit;
    logic [15:0]        depth_map [CELLS];
    int                 filled_cells [$];
    t_cell_word         pending_reads [$];

    int rmat [3][3];
    int cam_t [3];

    int errors;
    int words_seen;
    int reads_sent;
    int projects_sent;
    int writes_seen;
    int burst_left;
    int idle_cycles;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------ predictor
    function automatic longint row_dot(logic [47:0] row, longint a, longint b, longint c);
        return longint'($signed(row[15:0])) * a + longint'($signed(row[31:16])) * b
             + longint'($signed(row[47:32])) * c;
    endfunction

    function automatic bit axis_pixel(input longint n, input longint d, input longint c,
                                      input longint lim, output int unsigned pix);
        longint q;
        longint r;
        longint s;
        q = n / d;
        r = n % d;
        pix = 0;
        if (r < 0) begin
            q -= 1;
            r += d;
        end
        s = q + c;
        if (s < -256 || (s == -256 && r == 0)) return 1'b0;
        if (s >= lim * 256) return 1'b0;
        pix = (s < 0) ? 0 : int'(s >>> 8);
        return 1'b1;
    endfunction

    function automatic void apply_word(t_point_cmd c);
        longint dx, dy, dz, vx, vy, vz, zs, lim;
        int unsigned u, v, pix_idx;
        t_cell_word w;
        logic [15:0] old;
        if (c.cmd == CMD_READ) begin
            w.idx   = c.idx;
            w.depth = '0;
            if (c.idx < CELLS) begin
                w.depth = depth_map[c.idx];
                depth_map[c.idx] = '0;
            end
            pending_reads = {pending_reads, w};
            return;
        end
        dx = longint'(c.x) - longint'($signed(trans_xy[23:0]));
        dy = longint'(c.y) - longint'($signed(trans_xy[47:24]));
        dz = longint'(c.z) - longint'($signed(trans_z));
        vx = row_dot(rot_rows[0], dx, dy, dz);
        vy = row_dot(rot_rows[1], dx, dy, dz);
        vz = row_dot(rot_rows[2], dx, dy, dz);
        if (vz <= 0) return;
        if (!axis_pixel(vx * longint'(focal_pair[19:0]), vz,
                        longint'(center_pair[19:0]), IMG_W, u)) return;
        if (!axis_pixel(vy * longint'(focal_pair[39:20]), vz,
                        longint'(center_pair[39:20]), IMG_H, v)) return;
        pix_idx = v * IMG_W + u;
        if (pix_idx >= CELLS) return;
        zs  = vz * 1000;
        lim = longint'(depth_limit) * Q26;
        if (zs >= lim) return;
        old = depth_map[pix_idx];
        if (old == 0 || longint'(old) * Q26 > zs) begin
            depth_map[pix_idx] = 16'(zs >>> 26);
            filled_cells = {filled_cells, int'(pix_idx)};
        end
    endfunction

    // ------------------------------------------------------------ checker
    always @(posedge i_clk) begin
        t_cell_word w;
        if (i_rst_n && o_done) begin
            words_seen++;
            if (pending_reads.size() == 0) begin
                $error("unexpected word: depth_mm %0d cell %0d", o_depth_mm, o_cell_index_out);
                errors++;
            end else begin
                w = pending_reads.pop_front();
                if (o_depth_mm !== w.depth) begin
                    $error("depth_mm: expected %0d, got %0d", w.depth, o_depth_mm);
                    errors++;
                end
                if (o_cell_index_out !== w.idx) begin
                    $error("cell_index_out: expected %0d, got %0d", w.idx, o_cell_index_out);
                    errors++;
                end
            end
        end
    end

    // watchdog: cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("watchdog expired, %0d words outstanding", pending_reads.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------ drivers
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        writes_seen++;
        case (idx)
            CFG_ROT_X:  rot_rows[0] = data[47:0];
            CFG_ROT_Y:  rot_rows[1] = data[47:0];
            CFG_ROT_Z:  rot_rows[2] = data[47:0];
            CFG_TRANS:  trans_xy    = data[47:0];
            CFG_TZ:     trans_z     = data[23:0];
            CFG_FOCAL:  focal_pair  = data[39:0];
            CFG_CENTER: center_pair = data[39:0];
            CFG_LIMIT:  depth_limit = data[15:0];
            default: ;
        endcase
    endtask

    task automatic send_word(t_point_cmd c);
        @(negedge i_clk);
        i_start      = 1'b1;
        i_command    = c.cmd;
        i_point_x    = c.x;
        i_point_y    = c.y;
        i_point_z    = c.z;
        i_cell_index = c.idx;
        do @(posedge i_clk); while (o_busy);
        apply_word(c);
        if (c.cmd == CMD_READ) reads_sent++;
        else projects_sent++;
        // end of burst: drop start for a random gap
        burst_left--;
        if (burst_left <= 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat ($urandom_range(0, 1) ? $urandom_range(0, 9) : 0) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // wait for every read word, then for the last project to drain
    task automatic settle();
        @(negedge i_clk);
        i_start = 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_point_cmd read_cmd(logic [IDX_W-1:0] idx);
        t_point_cmd c;
        c = '{CMD_READ, '0, '0, '0, idx};
        return c;
    endfunction

    function automatic t_point_cmd proj_cmd(int x, int y, int z);
        t_point_cmd c;
        c = '{CMD_PROJECT, 24'(x), 24'(y), 24'(z), 19'($urandom)};
        return c;
    endfunction

    task automatic set_camera(int fx, int fy, int cx, int cy);
        write_reg(CFG_FOCAL,  {8'd0, 20'(fy), 20'(fx)});
        write_reg(CFG_CENTER, {8'd0, 20'(cy), 20'(cx)});
    endtask

    // signed axis permutation as the inverse rotation
    task automatic set_rotation(bit random_axes);
        int perm [3];
        int k;
        int j;
        int swap;
        perm = '{0, 1, 2};
        if (random_axes) begin
            for (k = 2; k > 0; k--) begin
                j = $urandom_range(0, k);
                swap = perm[k];
                perm[k] = perm[j];
                perm[j] = swap;
            end
        end
        for (k = 0; k < 3; k++) begin
            for (j = 0; j < 3; j++) rmat[k][j] = 0;
            rmat[k][perm[k]] = (random_axes && $urandom_range(0, 1)) ? -1 : 1;
        end
        write_reg(CFG_ROT_X, {16'(rmat[0][2] * Q14), 16'(rmat[0][1] * Q14), 16'(rmat[0][0] * Q14)});
        write_reg(CFG_ROT_Y, {16'(rmat[1][2] * Q14), 16'(rmat[1][1] * Q14), 16'(rmat[1][0] * Q14)});
        write_reg(CFG_ROT_Z, {16'(rmat[2][2] * Q14), 16'(rmat[2][1] * Q14), 16'(rmat[2][0] * Q14)});
    endtask

    task automatic set_translation(int tx, int ty, int tz);
        cam_t = '{tx, ty, tz};
        write_reg(CFG_TRANS, {24'(ty), 24'(tx)});
        write_reg(CFG_TZ, 48'(24'(tz)));
    endtask

    // point in front of the camera, often along a few shared rays
    function automatic t_point_cmd scene_point();
        int cam [3];
        int w [3];
        int k;
        int j;
        cam[2] = $urandom_range(200, 48000);
        if ($urandom_range(0, 1)) begin
            k = $urandom_range(0, 7);
            cam[0] = (k - 4) * cam[2] / 16;
            cam[1] = ((k * 3) % 8 - 4) * cam[2] / 16;
        end else begin
            cam[0] = (int'($urandom_range(0, 2 * cam[2])) - cam[2]) * 3 / 4;
            cam[1] = (int'($urandom_range(0, 2 * cam[2])) - cam[2]) * 3 / 4;
        end
        for (j = 0; j < 3; j++) begin
            w[j] = cam_t[j];
            for (k = 0; k < 3; k++) w[j] += rmat[k][j] * cam[k];
        end
        return proj_cmd(w[0], w[1], w[2]);
    endfunction

    function automatic t_point_cmd random_read();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 8 && filled_cells.size() != 0)
            return read_cmd(19'(filled_cells[$urandom_range(0, filled_cells.size() - 1)]));
        if (pick == 9) return read_cmd(19'($urandom));
        return read_cmd(19'($urandom_range(0, CELLS - 1)));
    endfunction

    // ------------------------------------------------------------ tests
    task automatic test_after_reset();
        send_word(read_cmd(19'd0));
        send_word(read_cmd(19'(CELLS - 1)));
        send_word(read_cmd(19'(CELLS)));
        send_word(read_cmd('1));
        settle();
    endtask

    task automatic test_zbuffer_basic();
        int centre;
        centre = 240 * IMG_W + 320;
        send_word(proj_cmd(0, 0, 4096));
        send_word(proj_cmd(0, 0, 8192));        // deeper: keep the nearer one
        send_word(proj_cmd(0, 0, 2048));        // nearer: overwrite
        send_word(read_cmd(19'(centre)));
        send_word(read_cmd(19'(centre)));       // cleared by the read above
        send_word(proj_cmd(8388607, -8388608, 8388607));
        send_word(proj_cmd(-8388608, 8388607, -8388608));
        send_word(proj_cmd(0, 0, 8388607));     // far beyond the limit
        send_word(proj_cmd(0, 0, 1));           // under a millimetre: stores zero
        send_word(proj_cmd(0, 0, -4096));       // behind the camera
        send_word(read_cmd(19'(centre)));
        settle();
    endtask

    task automatic test_corner_cases();
        set_camera(256, 256, 0, 0);
        send_word(proj_cmd(-2048, -2048, 4096));   // just left of and above pixel 0
        send_word(proj_cmd(-4096, 0, 4096));       // exactly one pixel off
        send_word(read_cmd(19'd0));
        settle();
        write_reg(CFG_LIMIT, 48'd0);
        send_word(proj_cmd(0, 0, 4096));
        send_word(read_cmd(19'd0));
        settle();
        write_reg(CFG_LIMIT, 48'd65535);
        send_word(proj_cmd(100, 100, 40000));
        send_word(read_cmd(19'd0));
        settle();
    endtask

    task automatic test_camera_sweep(int phases, int per_phase);
        int p;
        int n;
        int limit_pick;
        for (p = 0; p < phases; p++) begin
            set_rotation(p != 0);
            set_translation(int'($urandom_range(0, 2097152)) - 1048576,
                            int'($urandom_range(0, 2097152)) - 1048576,
                            int'($urandom_range(0, 2097152)) - 1048576);
            set_camera($urandom_range(200 * 256, 800 * 256), $urandom_range(200 * 256, 800 * 256),
                       $urandom_range(250 * 256, 390 * 256), $urandom_range(180 * 256, 300 * 256));
            limit_pick = $urandom_range(0, 5);
            write_reg(CFG_LIMIT, (limit_pick == 0) ? 48'd1 : (limit_pick == 1) ? 48'd65535
                                 : 48'($urandom_range(1000, 20000)));
            for (n = 0; n < per_phase; n++) begin
                send_word(($urandom_range(0, 9) < 7) ? scene_point() : random_read());
            end
            settle();
        end
    endtask

    task automatic test_random_noise(int count);
        t_point_cmd c;
        int n;
        write_reg(CFG_ROT_X,  48'({$urandom, $urandom}));
        write_reg(CFG_ROT_Y,  48'({$urandom, $urandom}));
        write_reg(CFG_ROT_Z,  48'({$urandom, $urandom}));
        write_reg(CFG_TRANS,  48'({$urandom, $urandom}));
        write_reg(CFG_TZ,     48'({$urandom, $urandom}));
        write_reg(CFG_FOCAL,  48'({$urandom, $urandom}));
        write_reg(CFG_CENTER, 48'({$urandom, $urandom}));
        write_reg(CFG_LIMIT,  48'({$urandom, $urandom}));
        for (n = 0; n < count; n++) begin
            c = '{1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), 19'($urandom)};
            send_word(c);
        end
        settle();
    endtask

    initial begin
        errors = 0;
        words_seen = 0;
        reads_sent = 0;
        projects_sent = 0;
        writes_seen = 0;
        burst_left = 4;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_command = CMD_PROJECT;
        i_point_x = '0;
        i_point_y = '0;
        i_point_z = '0;
        i_cell_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_ROT_X;
        i_cfg_data = '0;
        rot_rows = '{default: '0};
        trans_xy = '0;
        trans_z = '0;
        focal_pair = '0;
        center_pair = '0;
        depth_limit = LIMIT_RESET;
        foreach (depth_map[k]) depth_map[k] = '0;
        cam_t = '{0, 0, 0};
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity camera, 500 px focal length, centre of the image
        set_rotation(1'b0);
        set_translation(0, 0, 0);
        set_camera(500 * 256, 500 * 256, 320 * 256, 240 * 256);

        test_after_reset();
        test_zbuffer_basic();
        test_corner_cases();
        test_camera_sweep(8, 170);
        test_random_noise(160);

        settle();
        if (pending_reads.size() != 0) begin
            $error("%0d read words never arrived", pending_reads.size());
            errors += pending_reads.size();
        end
        $display("%0d projections and %0d reads sent, %0d words checked, %0d register writes",
                 projects_sent, reads_sent, words_seen, writes_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
